// ===== src/vp8_rtp_packetizer_assert.svh =====
// Assertion macros shared by the VP8 RTP packetizer modules.
// No dependencies; each module includes this file where it asserts.
`ifndef VP8_RTP_PACKETIZER_ASSERT_SVH
`define VP8_RTP_PACKETIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VRP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vrp_pkg.sv =====
// Shared types, codes and helpers for the VP8 RTP packetizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vrp_pkg;

  // Picture ID modes; the unused code behaves as none.
  localparam logic [1:0] ID_NONE    = 2'd0;
  localparam logic [1:0] ID_SEVEN   = 2'd1;
  localparam logic [1:0] ID_FIFTEEN = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ID_MODE  = 2'd0;
  localparam logic [1:0] REG_ID_START = 2'd1;
  localparam logic [1:0] REG_MTU      = 2'd2;
  localparam logic [1:0] REG_CSRC     = 2'd3;

  localparam logic [15:0] MTU_RESET     = 16'd1400;
  localparam logic [6:0]  RTP_HDR_BYTES = 7'd12;
  localparam logic [15:0] MIN_FRAME     = 16'd3;
  localparam logic [7:0]  TL0_RESET     = 8'hFF;
  localparam int          START_BIT     = 44;   // S bit inside the first descriptor byte

  typedef struct packed {
    logic        action;
    logic [15:0] frame_size;
    logic        droppable;
    logic        is_delta;
    logic        temporal_request;
    logic [1:0]  tid;
    logic        sync_bit;
  } item_t;

  typedef struct packed {
    logic [47:0] descriptor;
    logic [2:0]  descriptor_len;
    logic [15:0] payload_offset;
    logic [15:0] payload_len;
    logic        marker;
    logic        delta_flag;
    logic        error;
    logic        last;
  } result_t;

  // Classified frame handed from front to back.
  typedef struct packed {
    logic        error;
    logic [47:0] desc;
    logic [2:0]  desc_len;
    logic [15:0] frame_size;
    logic [15:0] slice_len;
    logic        delta;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  id_mode;
    logic [15:0] mtu;
    logic [3:0]  csrc_count;
  } cfg_t;

  typedef struct packed {
    logic        load;
    logic [14:0] value;
  } pic_load_t;

  function automatic logic [14:0] mask_pic(input logic [1:0] mode, input logic [14:0] v);
    logic [14:0] r;
    r = 15'd0;
    if (mode == ID_SEVEN) begin
      r = {8'd0, v[6:0]};
    end else if (mode == ID_FIFTEEN) begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/vp8_rtp_packetizer.sv =====
// VP8 RTP packetizer, top level: configuration registers, front, queue, back.
// Depends on vrp_pkg, vrp_front, vrp_queue and vrp_back.
//
// Push a frame descriptor (action 0) or a gap/flush event (action 1). A frame
// is cut into slices that fit the MTU after the 12-byte RTP header, four
// bytes per CSRC and the RFC 7741 payload descriptor, and one result per slice
// comes out of the result queue, with marker and last on the final one. PartID
// is always 0 and S is set on the first packet only. A frame under 3 bytes, or
// one needing more than MAX_PACKETS packets (or an MTU with no payload room),
// gives a single result with only error and last set, and leaves the picture
// ID and layer state alone. An event gives no result; it only advances the
// picture ID. Rate: the front end takes one item per cycle while its
// two-entry command queue has room; the back end loads a command only while idle
// and then emits one result per packet of it, so it takes the next command only
// after the last packet of the current one (or its error result) is emitted.
// Result pops stall the back end only through the single result register.
// Write configuration only while the block is idle; writing id_mode or
// id_start reloads the picture ID, masked to the mode width.
`timescale 1ns / 1ps

module vp8_rtp_packetizer import vrp_pkg::*; #(
  parameter int MAX_PACKETS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input item queue
  input  logic        push,
  output logic        full,
  input  item_t       item,
  // result queue
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  id_mode;
  logic [14:0] id_start;
  logic [15:0] mtu;
  logic [3:0]  csrc_count;

  logic        cfg_wr;
  logic [1:0]  reg_idx;
  logic [1:0]  mode_next;
  logic [14:0] start_next;
  cfg_t        cfg;
  pic_load_t   pic_load;

  logic cmd_wr;
  cmd_t cmd;
  logic cmd_full;
  logic q_rd;
  logic q_empty;
  cmd_t q_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register read back; every index maps to a register.
  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      REG_ID_MODE:  prdata = {30'd0, id_mode};
      REG_ID_START: prdata = {17'd0, id_start};
      REG_MTU:      prdata = {16'd0, mtu};
      REG_CSRC:     prdata = {28'd0, csrc_count};
    endcase
  end

  // Reload the picture ID from the values that this transfer leaves behind.
  assign mode_next  = (cfg_wr && reg_idx == REG_ID_MODE)  ? pwdata[1:0]  : id_mode;
  assign start_next = (cfg_wr && reg_idx == REG_ID_START) ? pwdata[14:0] : id_start;
  assign pic_load.load  = cfg_wr && (reg_idx == REG_ID_MODE || reg_idx == REG_ID_START);
  assign pic_load.value = mask_pic(mode_next, start_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      id_mode    <= ID_NONE;
      id_start   <= 15'd0;
      mtu        <= MTU_RESET;
      csrc_count <= 4'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ID_MODE:  id_mode    <= pwdata[1:0];
        REG_ID_START: id_start   <= pwdata[14:0];
        REG_MTU:      mtu        <= pwdata[15:0];
        REG_CSRC:     csrc_count <= pwdata[3:0];
      endcase
    end
  end

  assign cfg.id_mode    = id_mode;
  assign cfg.mtu        = mtu;
  assign cfg.csrc_count = csrc_count;

  vrp_front #(
    .MAX_PACKETS(MAX_PACKETS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pic_load (pic_load),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_wr   (cmd_wr),
    .cmd      (cmd),
    .cmd_full (cmd_full)
  );

  vrp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_wr),
    .wr_data (cmd),
    .full    (cmd_full),
    .rd      (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  vrp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== src/vrp_front.sv =====
// Front end: accepts items, builds the payload descriptor and checks the frame.
// Depends on vrp_pkg; owns picture ID, TL0 index and temporal flag.
`timescale 1ns / 1ps

module vrp_front import vrp_pkg::*; #(
  parameter int MAX_PACKETS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  pic_load_t pic_load,
  input  logic      push,
  output logic      full,
  input  item_t     item,
  output logic      cmd_wr,
  output cmd_t      cmd,
  input  logic      cmd_full
);

  localparam int PW = 16 + $clog2(MAX_PACKETS + 1);

  logic [14:0] picture_number;
  logic [7:0]  base_layer_index;
  logic        temporal_present;

  logic        accept;
  logic        tp;
  logic [1:0]  layer;
  logic        sync;
  logic        x_bit;
  logic        id_on;
  logic [2:0]  hlen;
  logic [6:0]  overhead;
  logic [15:0] pl;
  logic [PW-1:0] limit;
  logic        bad;
  logic [7:0]  tl0_next;
  logic [7:0]  b0;
  logic [7:0]  ext;
  logic [15:0] tl;
  logic [47:0] desc;

  assign full   = cmd_full;
  assign accept = push && !full;

  always_comb begin
    tp    = temporal_present | item.temporal_request;
    layer = item.temporal_request ? item.tid : 2'd0;
    sync  = item.temporal_request & item.sync_bit;
    id_on = (cfg.id_mode == ID_SEVEN) || (cfg.id_mode == ID_FIFTEEN);
    x_bit = id_on || tp;

    hlen = 3'd1;
    if (x_bit) begin
      hlen = 3'd2 + (tp ? 3'd2 : 3'd0) +
             ((cfg.id_mode == ID_SEVEN) ? 3'd1 : (cfg.id_mode == ID_FIFTEEN) ? 3'd2 : 3'd0);
    end
    overhead = {4'd0, hlen} + RTP_HDR_BYTES + {1'b0, cfg.csrc_count, 2'b00};
    pl       = (cfg.mtu > {9'd0, overhead}) ? (cfg.mtu - {9'd0, overhead}) : 16'd0;
    limit    = PW'(pl) * PW'(MAX_PACKETS);
    bad      = (item.frame_size < MIN_FRAME) || (pl == 16'd0) ||
               (PW'(item.frame_size) > limit);

    // Bump TL0PICIDX on a base-layer frame while temporal fields are on.
    tl0_next = (tp && layer == 2'd0) ? base_layer_index + 8'd1 : base_layer_index;

    b0  = {x_bit, 1'b0, item.droppable, 5'd0};
    ext = {id_on, tp, tp, 5'd0};
    tl  = tp ? {tl0_next, layer, sync, 5'd0} : 16'd0;
    desc = {b0, 40'd0};
    if (x_bit) begin
      unique case (cfg.id_mode)
        ID_SEVEN:   desc = {b0, ext, 1'b0, picture_number[6:0], tl, 8'd0};
        ID_FIFTEEN: desc = {b0, ext, 1'b1, picture_number[14:8], picture_number[7:0], tl};
        default:    desc = {b0, ext, tl, 16'd0};
      endcase
    end

    cmd            = '0;
    cmd.error      = bad;
    if (!bad) begin
      cmd.desc       = desc;
      cmd.desc_len   = hlen;
      cmd.frame_size = item.frame_size;
      cmd.slice_len  = pl;
      cmd.delta      = item.is_delta;
    end
  end

  assign cmd_wr = accept && !item.action;

  always_ff @(posedge clk) begin
    if (rst) begin
      picture_number   <= 15'd0;
      base_layer_index <= TL0_RESET;
      temporal_present <= 1'b0;
    end else if (pic_load.load) begin
      picture_number <= pic_load.value;
    end else if (accept && (item.action || !bad)) begin
      picture_number <= mask_pic(cfg.id_mode, picture_number + 15'd1);
      if (!item.action) begin
        temporal_present <= tp;
        base_layer_index <= tl0_next;
      end
    end
  end

endmodule

// ===== src/vrp_queue.sv =====
// Two-entry command queue between the front and back ends.
// Depends on vrp_pkg for the command type.
`timescale 1ns / 1ps

`include "vp8_rtp_packetizer_assert.svh"

module vrp_queue import vrp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd,
  output cmd_t rd_data,
  output logic empty
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full    = (count == (AW + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + AW'(1);
      if (rd) rd_ptr <= rd_ptr + AW'(1);
      count <= count + (AW + 1)'(wr) - (AW + 1)'(rd);
    end
  end

  `VRP_ASSERT_IMPLY(a_no_overflow, clk, rst, wr, !full || rd, "queue written while full")
  `VRP_ASSERT_IMPLY(a_no_underflow, clk, rst, rd, !empty, "queue read while empty")

endmodule

// ===== src/vrp_back.sv =====
// Back end: walks one queued command into packet results.
// Depends on vrp_pkg; drives the result register of the block.
`timescale 1ns / 1ps

`include "vp8_rtp_packetizer_assert.svh"

module vrp_back import vrp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  cmd_t    q_data,
  output logic    q_rd,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  cmd_t        cur;
  logic        busy;
  logic        first;
  logic [15:0] offset;
  logic        out_valid;

  logic        out_free;
  logic        emit;
  logic [15:0] remaining;
  logic        fits;
  logic [15:0] avail;
  result_t     pkt;

  assign out_free = !out_valid || pop;
  assign q_rd     = !busy && !q_empty;
  assign emit     = busy && out_free;
  assign empty    = !out_valid;

  always_comb begin
    remaining = cur.frame_size - offset;
    fits      = cur.slice_len >= remaining;
    avail     = fits ? remaining : cur.slice_len;

    pkt = '0;
    if (cur.error) begin
      pkt.error = 1'b1;
      pkt.last  = 1'b1;
    end else begin
      pkt.descriptor     = cur.desc;
      pkt.descriptor[START_BIT] = first;
      pkt.descriptor_len = cur.desc_len;
      pkt.payload_offset = offset;
      pkt.payload_len    = avail;
      pkt.marker         = fits;
      pkt.delta_flag     = first ? cur.delta : 1'b1;
      pkt.last           = fits;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
    if (emit) begin
      result <= pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      first     <= 1'b0;
      offset    <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_rd) begin
        busy   <= 1'b1;
        first  <= 1'b1;
        offset <= 16'd0;
      end else if (emit) begin
        first  <= 1'b0;
        offset <= offset + avail;
        if (cur.error || fits) busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `VRP_ASSERT_IMPLY(a_err_shape, clk, rst, out_valid && result.error,
                    result.last && !result.marker && result.descriptor_len == 3'd0,
                    "error result not in its fixed form")
  `VRP_ASSERT_IMPLY(a_mark_last, clk, rst, out_valid && !result.error,
                    result.marker == result.last && result.payload_len != 16'd0,
                    "packet result with bad marker or empty slice")
  `VRP_ASSERT_NEXT(a_frame_end, clk, rst, emit && (cur.error || fits), !busy,
                   "back end still busy after the last packet")

endmodule

// ===== tb/vp8_rtp_packetizer_tb.sv =====
// Self-checking testbench for the VP8 RTP packetizer: directed and random frames.
// Depends on vrp_pkg for the item, result and register codes.
`timescale 1ns / 1ps

module vp8_rtp_packetizer_tb;
  import vrp_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int MAX_PACKETS    = 64;
  localparam int IDLE_PCT       = 17;
  localparam int TIMEOUT_CYCLES = 600_000;

  // Unused picture ID mode code; the block treats it as no picture ID.
  localparam logic [1:0] ID_UNUSED = 2'd3;

  // Payload descriptor bits.
  localparam logic [7:0] DESC_X  = 8'h80;  // extension byte present
  localparam logic [7:0] DESC_I  = 8'h80;  // picture ID present
  localparam logic [7:0] DESC_LT = 8'h60;  // TL0PICIDX and TID/Y present

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        push    = 1'b0;
  logic        full;
  item_t       item    = '0;
  logic        empty;
  logic        pop     = 1'b0;
  result_t     result;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  vp8_rtp_packetizer #(.MAX_PACKETS(MAX_PACKETS)) i_dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the registers and the packetizer state.
  logic [1:0]  cfg_id_mode  = ID_NONE;
  logic [14:0] cfg_id_start = '0;
  logic [15:0] cfg_mtu      = MTU_RESET;
  logic [3:0]  cfg_csrc     = '0;
  logic [14:0] pic_id       = '0;
  logic [7:0]  tl0_index    = TL0_RESET;
  logic        temporal_on  = 1'b0;

  item_t   frames_to_push[$];    // items waiting for the driver
  result_t outgoing_packets[$];  // packets the block still owes, oldest first

  bit no_gaps = 1'b0;            // when set, both sides transfer every cycle they can
  int frames_pushed   = 0;
  int gaps_pushed     = 0;
  int packets_checked = 0;
  int rejects_seen    = 0;
  int settings_used   = 0;
  int mismatches      = 0;

  function automatic int id_width();
    case (cfg_id_mode)
      ID_SEVEN:   return 7;
      ID_FIFTEEN: return 15;
      default:    return 0;
    endcase
  endfunction

  // Payload bytes left in one packet after RTP header, CSRCs and descriptor.
  function automatic int slice_room(input bit tp);
    int w, desc_len, overhead;
    w = id_width();
    desc_len = (w == 7) ? 1 : (w == 15) ? 2 : 0;
    if (tp) desc_len += 2;
    if (desc_len != 0) desc_len += 1;
    desc_len += 1;
    overhead = desc_len + int'(RTP_HDR_BYTES) + 4 * int'(cfg_csrc);
    return (int'(cfg_mtu) > overhead) ? int'(cfg_mtu) - overhead : 0;
  endfunction

  task automatic reload_picture();
    int w;
    w = id_width();
    pic_id = (w != 0) ? 15'(int'(cfg_id_start) & ((1 << w) - 1)) : 15'd0;
  endtask

  task automatic step_picture();
    int w;
    w = id_width();
    if (w != 0) pic_id = 15'((int'(pic_id) + 1) & ((1 << w) - 1));
  endtask

  // Cut one accepted item into the packets it must produce and queue them.
  task automatic packetize(input item_t it);
    int w, room, npk, size, offset, remaining, avail, n;
    bit tp, first, mark;
    logic [1:0] layer;
    logic sync;
    logic [7:0] hdr [6];
    result_t pkt;
    w = id_width();
    if (it.action) begin
      step_picture();
      return;
    end
    tp = temporal_on | it.temporal_request;
    layer = it.temporal_request ? it.tid : 2'd0;
    sync = it.temporal_request & it.sync_bit;
    room = slice_room(tp);
    size = int'(it.frame_size);
    npk = (room > 0) ? (size + room - 1) / room : 0;
    if (size < int'(MIN_FRAME) || room == 0 || npk > MAX_PACKETS) begin
      pkt = '0;
      pkt.error = 1'b1;
      pkt.last = 1'b1;
      outgoing_packets.push_back(pkt);
      return;
    end
    temporal_on = tp;
    offset = 0;
    for (int k = 0; k < npk; k++) begin
      first = (k == 0);
      remaining = size - offset;
      avail = (room < remaining) ? room : remaining;
      mark = (avail == remaining);
      for (int j = 0; j < 6; j++) hdr[j] = 8'h00;
      hdr[0] = {2'b00, it.droppable, first, 4'h0};
      n = 1;
      if (w != 0 || tp) begin
        hdr[0] |= DESC_X;
        hdr[1] = ((w != 0) ? DESC_I : 8'h00) | (tp ? DESC_LT : 8'h00);
        n = 2;
        if (w == 7) begin
          hdr[2] = {1'b0, pic_id[6:0]};
          n = 3;
        end else if (w == 15) begin
          hdr[2] = {1'b1, pic_id[14:8]};  // M bit marks the long form
          hdr[3] = pic_id[7:0];
          n = 4;
        end
        if (tp) begin
          if (layer == 2'd0 && first) tl0_index++;
          hdr[n] = tl0_index;
          hdr[n + 1] = {layer, sync, 5'b00000};
          n += 2;
        end
      end
      pkt.descriptor     = {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5]};
      pkt.descriptor_len = 3'(n);
      pkt.payload_offset = 16'(offset);
      pkt.payload_len    = 16'(avail);
      pkt.marker         = mark;
      pkt.delta_flag     = first ? it.is_delta : 1'b1;
      pkt.error          = 1'b0;
      pkt.last           = mark;
      outgoing_packets.push_back(pkt);
      offset += avail;
    end
    step_picture();
  endtask

  task automatic compare_field(input string name, input logic [47:0] want,
                               input logic [47:0] seen);
    if (seen !== want) begin
      $display("%0t: packet %0d %s expected %0h got %0h",
               $time, packets_checked, name, want, seen);
      mismatches++;
    end
  endtask

  task automatic check_packet(input result_t got);
    result_t want;
    if (outgoing_packets.size() == 0) begin
      $display("%0t: unexpected packet, expected none got %0h", $time, got);
      mismatches++;
      return;
    end
    want = outgoing_packets.pop_front();
    compare_field("descriptor", want.descriptor, got.descriptor);
    compare_field("descriptor_len", want.descriptor_len, got.descriptor_len);
    compare_field("payload_offset", want.payload_offset, got.payload_offset);
    compare_field("payload_len", want.payload_len, got.payload_len);
    compare_field("marker", want.marker, got.marker);
    compare_field("delta_flag", want.delta_flag, got.delta_flag);
    compare_field("error", want.error, got.error);
    compare_field("last", want.last, got.last);
    if (want.error) rejects_seen++;
    packets_checked++;
  endtask

  // Input side: predict each item at the edge it transfers, then offer the
  // next pending item, or idle now and then.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        packetize(item);
        if (item.action) gaps_pushed++;
        else frames_pushed++;
      end
      // Hold the current item while the block is full.
      if (!push || !full) begin
        if (frames_to_push.size() > 0 &&
            (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
          item <= frames_to_push.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result side: check every transfer, stall pop at random.
  always @(posedge clk) begin
    if (!rst && pop && !empty) check_packet(result);
    pop <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Write one register through the setup and access phases, then mirror it.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      REG_ID_MODE: begin
        cfg_id_mode = value[1:0];
        reload_picture();
      end
      REG_ID_START: begin
        cfg_id_start = value[14:0];
        reload_picture();
      end
      REG_MTU:  cfg_mtu = value[15:0];
      REG_CSRC: cfg_csrc = value[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [1:0] mode, input int start, input int mtu,
                           input int csrc);
    write_reg(REG_ID_MODE, 32'(mode));
    write_reg(REG_ID_START, 32'(start));
    write_reg(REG_MTU, 32'(mtu));
    write_reg(REG_CSRC, 32'(csrc));
    settings_used++;
  endtask

  task automatic queue_frame(input int size, input bit drop, input bit delta,
                             input bit treq, input int layer, input bit sync);
    item_t it;
    it.action           = 1'b0;
    it.frame_size       = 16'(size);
    it.droppable        = drop;
    it.is_delta         = delta;
    it.temporal_request = treq;
    it.tid              = 2'(layer);
    it.sync_bit         = sync;
    frames_to_push.push_back(it);
  endtask

  task automatic queue_gap();
    item_t it;
    it = '0;
    it.action = 1'b1;
    frames_to_push.push_back(it);
  endtask

  // Random items: mostly frames of a few packets, some near the packet limit,
  // some short, some of any size, and gap events with junk in the other fields.
  task automatic queue_random(input int count, input bit allow_temporal);
    item_t it;
    int room, r, lo, hi, size;
    repeat (count) begin
      it.action           = ($urandom_range(0, 99) < 12);
      it.droppable        = $urandom_range(0, 1);
      it.is_delta         = $urandom_range(0, 1);
      it.temporal_request = allow_temporal ? $urandom_range(0, 1) : 1'b0;
      it.tid              = $urandom_range(0, 3);
      it.sync_bit         = $urandom_range(0, 1);
      room = slice_room(temporal_on | it.temporal_request);
      if (room < 1) room = 1;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        size = $urandom_range(0, 4);
      end else if (r < 14) begin
        hi = room * (MAX_PACKETS + 1);
        if (hi > 65535) hi = 65535;
        lo = room * (MAX_PACKETS - 1);
        if (lo > hi) lo = hi / 2;
        size = $urandom_range(hi, lo);
      end else if (r < 26) begin
        size = $urandom_range(0, 65535);
      end else begin
        hi = room * 4;
        if (hi > 65535) hi = 65535;
        size = $urandom_range(hi, 3);
      end
      it.frame_size = 16'(size);
      frames_to_push.push_back(it);
    end
  endtask

  // Wait until every item has transferred and every packet has come back,
  // then let the block settle before touching the registers.
  task automatic drain();
    do @(posedge clk);
    while (frames_to_push.size() != 0 || push || outgoing_packets.size() != 0);
    repeat (MAX_PACKETS + 8) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // No picture ID, no temporal fields yet: short frames, the smallest
    // legal frame, exact one-packet fit, one byte over, the largest frame.
    configure(ID_NONE, 15'h1234, 1400, 0);
    queue_frame(0, 0, 0, 0, 0, 0);
    queue_frame(1, 0, 1, 0, 0, 0);
    queue_frame(2, 1, 0, 0, 0, 0);
    queue_frame(3, 1, 0, 0, 0, 0);
    queue_frame(1387, 0, 1, 0, 0, 0);
    queue_frame(1388, 1, 1, 0, 0, 0);
    queue_frame(65535, 0, 0, 0, 0, 0);
    queue_gap();
    queue_frame(500, 1, 1, 0, 0, 0);
    queue_random(40, 1'b0);
    drain();

    // Long picture IDs that wrap, temporal fields switched on and then left
    // sticky, layer bits ignored without a request, short frame untouched.
    configure(ID_FIFTEEN, 32766, 65535, 0);
    queue_frame(100, 0, 0, 1, 0, 1);
    queue_frame(65535, 1, 1, 1, 3, 0);
    queue_gap();
    queue_frame(40, 0, 1, 0, 2, 1);
    queue_frame(2, 1, 1, 1, 0, 1);
    queue_frame(777, 0, 1, 1, 1, 1);
    queue_random(45, 1'b1);
    drain();

    // MTU of 128 and the most CSRCs: exactly the packet limit and one byte over.
    // Run this one without idling on either side.
    configure(ID_SEVEN, 126, 128, 15);
    no_gaps = 1'b1;
    queue_frame(3264, 0, 0, 1, 0, 0);
    queue_frame(3265, 0, 0, 1, 1, 0);
    queue_gap();
    queue_frame(51, 1, 0, 0, 0, 0);
    queue_frame(52, 0, 1, 1, 2, 1);
    queue_random(60, 1'b1);
    drain();
    no_gaps = 1'b0;

    configure(ID_UNUSED, 15'h7FFF, 576, 7);
    queue_random(50, 1'b1);
    drain();

    configure(ID_FIFTEEN, 0, 9000, 3);
    queue_random(50, 1'b1);
    drain();

    // MTU too small for any payload: every frame is rejected.
    configure(ID_SEVEN, 15'h5A5A, 16, 0);
    queue_frame(3, 0, 0, 1, 0, 0);
    queue_frame(1000, 1, 1, 0, 0, 0);
    queue_gap();
    queue_frame(2, 0, 0, 0, 0, 0);
    drain();

    configure(ID_NONE, 15'h002A, 1500, 1);
    queue_random(55, 1'b1);
    drain();

    $display("Covered %0d frames and %0d gap events under %0d register settings;",
             frames_pushed, gaps_pushed, settings_used);
    $display("checked %0d packets, %0d of them rejected frames, %0d mismatches.",
             packets_checked, rejects_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Bound the run in case a transfer never completes.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d items unsent and %0d packets outstanding",
             frames_to_push.size(), outgoing_packets.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== vp8_rtp_packetizer.f =====
+incdir+src
src/vrp_pkg.sv
src/vrp_front.sv
src/vrp_queue.sv
src/vrp_back.sv
src/vp8_rtp_packetizer.sv
tb/vp8_rtp_packetizer_tb.sv
